>>> rtl/ppm_pkg.sv
// Package: shared types and constants for the pairwise proximity monitor.
package ppm_pkg;

  localparam int POS_W    = 24;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 24;
  localparam int DIST_W   = 25;
  localparam int ID_W     = 8;
  localparam int CNT_W    = 32;
  localparam int SUM_W    = 2 * POS_W + 4;
  localparam int ROOT_W   = SUM_W / 2;
  localparam logic [THR_W-1:0] SAFETY_RESET = THR_W'(256);

  typedef struct packed {
    logic signed [POS_W-1:0] ax;
    logic signed [POS_W-1:0] ay;
    logic signed [POS_W-1:0] az;
    logic signed [POS_W-1:0] bx;
    logic signed [POS_W-1:0] by;
    logic signed [POS_W-1:0] bz;
    logic [TIME_W-1:0]       stamp;
    logic [ID_W-1:0]         drone_a;
    logic [ID_W-1:0]         drone_b;
    logic                    first_of_pair;
    logic                    clear_stats;
    logic [THR_W-1:0]        threshold_override;
  } in_item_t;

  typedef struct packed {
    logic                    collision;
    logic [DIST_W-1:0]       distance;
    logic signed [POS_W-1:0] mid_x;
    logic signed [POS_W-1:0] mid_y;
    logic signed [POS_W-1:0] mid_z;
    logic [TIME_W-1:0]       stamp_out;
    logic [ID_W-1:0]         drone_a_out;
    logic [ID_W-1:0]         drone_b_out;
    logic [DIST_W-1:0]       closest_dist;
    logic [TIME_W-1:0]       min_stamp;
    logic [CNT_W-1:0]        check_count;
    logic [CNT_W-1:0]        hit_count;
  } out_item_t;

  // Partial state handed from one root cell to the next.
  typedef struct packed {
    logic [SUM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_link_t;

endpackage

>>> rtl/ppm_sqrt_cell.sv
// One cell of the digit-by-digit square root chain: one result bit per cycle while en is high.
module ppm_sqrt_cell #(
  parameter int SUM_W  = ppm_pkg::SUM_W,
  parameter int ROOT_W = ppm_pkg::ROOT_W,
  parameter int STEP   = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  rem_in,
  input  logic [ROOT_W-1:0] root_in,
  output logic [SUM_W-1:0]  rem_out,
  output logic [ROOT_W-1:0] root_out
);

  localparam int SH = 2 * (ROOT_W - 1 - STEP);

  logic [SUM_W+1:0] trial;
  logic [SUM_W+1:0] rem_ext;

  // Trial subtrahend (4*root + 1) aligned to the current digit pair.
  always_comb begin
    trial   = ({2'b00, SUM_W'({root_in, 2'b01})}) << SH;
    rem_ext = {2'b00, rem_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_ext >= trial) begin
        rem_out  <= SUM_W'(rem_ext - trial);
        root_out <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_out  <= rem_in;
        root_out <= {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/pairwise_proximity_monitor_core.sv
// Top level: proximity monitor with a square root cell chain.
//
// Usage: present a pair sample on in_data with in_valid; it is taken when
// in_ready is also high. The block computes per-axis differences, squares
// them (one multiplier per axis, registered), sums them, then walks a chain
// of ROOT_W square root cells, one result bit per cell per cycle. The result
// transaction appears on out_data with out_valid and is held until out_ready.
// The sample passes the difference, square and sum registers and then the
// root cells before out_valid rises; one transaction is in flight at a
// time, so a new sample is taken only after the previous result has been
// accepted with out_ready.
// in_ready is high whenever no transaction is in flight.
// A stalled receiver keeps out_valid high and in_ready low.
// Reset clears the counters, the minimum tracker (to all ones) and the
// safety distance (to 1.0). cfg_we writes the safety threshold at once.
module pairwise_proximity_monitor_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ppm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ppm_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [ppm_pkg::THR_W-1:0] cfg_wdata
);

  localparam int POS_WIDTH  = ppm_pkg::POS_W;
  localparam int TIME_WIDTH = ppm_pkg::TIME_W;
  localparam int SUM_W  = 2 * POS_WIDTH + 4;
  localparam int ROOT_W = SUM_W / 2;
  localparam int DW     = ppm_pkg::DIST_W;
  localparam int NSTG   = ROOT_W + 4;
  localparam int CW     = $clog2(NSTG + 1);

  logic               busy_r, busy_nxt;
  logic               out_valid_r;
  logic [CW-1:0]      cnt_r;
  ppm_pkg::in_item_t  item_r;
  logic [ppm_pkg::THR_W-1:0] safety_r;
  logic [ppm_pkg::CNT_W-1:0] checks_r, hits_r;
  logic [DW-1:0]      best_r;
  logic [TIME_WIDTH-1:0] best_stamp_r;
  ppm_pkg::out_item_t out_r;

  logic [POS_WIDTH:0]  dx_r, dy_r, dz_r;
  logic [2*POS_WIDTH+1:0] sx_r, sy_r, sz_r;
  logic [SUM_W-1:0]    sum_r;

  logic [SUM_W-1:0]    rem_c  [ROOT_W+1];
  logic [ROOT_W-1:0]   root_c [ROOT_W+1];

  logic                accept_in;
  logic                chain_en;

  assign accept_in = in_valid && in_ready;
  assign in_ready  = !busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign chain_en  = busy_r && !out_valid_r;

  // Magnitudes of per-axis differences.
  function automatic logic [POS_WIDTH:0] absdiff(input logic [POS_WIDTH-1:0] a,
                                                 input logic [POS_WIDTH-1:0] b);
    logic signed [POS_WIDTH:0] d;
    d = $signed({a[POS_WIDTH-1], a}) - $signed({b[POS_WIDTH-1], b});
    absdiff = d[POS_WIDTH] ? (POS_WIDTH+1)'(-d) : (POS_WIDTH+1)'(d);
  endfunction

  function automatic logic [POS_WIDTH-1:0] fmid(input logic [POS_WIDTH-1:0] a,
                                                input logic [POS_WIDTH-1:0] b);
    logic [POS_WIDTH:0] s;
    s = {a[POS_WIDTH-1], a} + {b[POS_WIDTH-1], b};
    fmid = s[POS_WIDTH:1];
  endfunction

  // Front end: difference, square, sum, one register each.
  always_ff @(posedge clk) begin
    if (chain_en) begin
      dx_r  <= absdiff(item_r.ax[POS_WIDTH-1:0], item_r.bx[POS_WIDTH-1:0]);
      dy_r  <= absdiff(item_r.ay[POS_WIDTH-1:0], item_r.by[POS_WIDTH-1:0]);
      dz_r  <= absdiff(item_r.az[POS_WIDTH-1:0], item_r.bz[POS_WIDTH-1:0]);
      sx_r  <= dx_r * dx_r;
      sy_r  <= dy_r * dy_r;
      sz_r  <= dz_r * dz_r;
      sum_r <= SUM_W'(sx_r) + SUM_W'(sy_r) + SUM_W'(sz_r);
    end
  end

  assign rem_c[0]  = sum_r;
  assign root_c[0] = '0;

  // Row of root cells; each resolves one bit and hands on.
  for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
    ppm_sqrt_cell #(.SUM_W(SUM_W), .ROOT_W(ROOT_W), .STEP(g)) u_cell (
      .clk     (clk),
      .en      (chain_en),
      .rem_in  (rem_c[g]),
      .root_in (root_c[g]),
      .rem_out (rem_c[g+1]),
      .root_out(root_c[g+1])
    );
  end

  logic [DW-1:0]               sep;
  logic [ppm_pkg::THR_W-1:0]   thr;
  logic                        hit;
  logic [ppm_pkg::CNT_W-1:0]   checks_nxt, hits_nxt;
  logic                        newbest;
  logic [DW-1:0]               base_best;
  logic [TIME_WIDTH-1:0]       base_stamp;

  always_comb begin
    sep  = DW'(root_c[ROOT_W]);
    thr  = (item_r.threshold_override != '0) ? item_r.threshold_override : safety_r;
    hit  = {1'b0, sep} < {2'b00, thr};
    checks_nxt = (item_r.clear_stats ? '0 : checks_r) + 1'b1;
    hits_nxt   = (item_r.clear_stats ? '0 : hits_r) + ppm_pkg::CNT_W'(hit);
    base_best  = item_r.first_of_pair ? '1 : best_r;
    base_stamp = item_r.first_of_pair ? '0 : best_stamp_r;
    newbest    = sep < base_best;
    busy_nxt   = busy_r;
    if (accept_in) busy_nxt = 1'b1;
    else if (out_valid_r && out_ready) busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      safety_r     <= ppm_pkg::SAFETY_RESET;
      checks_r     <= '0;
      hits_r       <= '0;
      best_r       <= '1;
      best_stamp_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      if (cfg_we) safety_r <= cfg_wdata;
      if (accept_in) begin
        item_r <= in_data;
        cnt_r  <= '0;
      end else if (chain_en) begin
        // Advance until the last cell has latched its bit.
        if (cnt_r == CW'(NSTG - 1)) begin
          out_valid_r <= 1'b1;
          checks_r    <= checks_nxt;
          hits_r      <= hits_nxt;
          best_r       <= newbest ? sep : base_best;
          best_stamp_r <= newbest ? item_r.stamp[TIME_WIDTH-1:0] : base_stamp;
          out_r.collision    <= hit;
          out_r.distance     <= sep;
          out_r.mid_x <= POS_WIDTH'(fmid(item_r.ax[POS_WIDTH-1:0], item_r.bx[POS_WIDTH-1:0]));
          out_r.mid_y <= POS_WIDTH'(fmid(item_r.ay[POS_WIDTH-1:0], item_r.by[POS_WIDTH-1:0]));
          out_r.mid_z <= POS_WIDTH'(fmid(item_r.az[POS_WIDTH-1:0], item_r.bz[POS_WIDTH-1:0]));
          out_r.stamp_out    <= item_r.stamp;
          out_r.drone_a_out  <= item_r.drone_a;
          out_r.drone_b_out  <= item_r.drone_b;
          out_r.closest_dist <= newbest ? sep : base_best;
          out_r.min_stamp    <= ppm_pkg::TIME_W'(newbest ? item_r.stamp[TIME_WIDTH-1:0]
                                                         : base_stamp);
          out_r.check_count  <= checks_nxt;
          out_r.hit_count    <= hits_nxt;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ready) else $error("input taken while busy");
  a_out_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> busy_r) else $error("result without transaction");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_r))
    else $error("result changed while stalled");

endmodule
